[sv/bitrd_pkg.sv]
`timescale 1ns / 1ps

package bitrd_pkg;

    // default depth of the byte buffer
    localparam int BUFFER_BYTES_DEF = 16;

    // longest fixed read, and the zero run that aborts a code
    localparam logic [6:0] MAX_FIXED_BITS = 7'd64;
    localparam logic [6:0] GOLOMB_LIMIT   = 7'd64;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_PUSH   = 2'd1,
        OP_FIXED  = 2'd2,
        OP_GOLOMB = 2'd3
    } op_t;

    // one classified request as it waits in the queue
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [6:0] count;
    } pkt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_WORK
    } state_t;

    typedef enum logic [1:0] {
        MD_FIXED,
        MD_ZERO,
        MD_SUFFIX
    } mode_t;

endpackage

[sv/bitrd_cmd_if.sv]
`timescale 1ns / 1ps

interface bitrd_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [6:0] bit_count;

    modport source (output valid, output req_type, output data_byte, output bit_count,
                    input ready);
    modport sink (input valid, input req_type, input data_byte, input bit_count,
                  output ready);
endinterface

[sv/bitrd_res_if.sv]
`timescale 1ns / 1ps

interface bitrd_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        error;
    logic        overflow;

    modport source (output valid, output value, output error, output overflow,
                    input ready);
    modport sink (input valid, input value, input error, input overflow,
                  output ready);
endinterface

[sv/bitrd_ram.sv]
`timescale 1ns / 1ps

module bitrd_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/bitrd_front.sv]
`timescale 1ns / 1ps

module bitrd_front (
    input  logic              clk,
    input  logic              rst_n,
    bitrd_cmd_if.sink         cmd,
    output bitrd_pkg::pkt_t   q_head,
    output logic              q_valid,
    input  logic              q_pop
);

    import bitrd_pkg::*;

    // two-entry queue towards the back end
    pkt_t       entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;
    pkt_t       pkt;

    // classify: decode the request and clamp the fixed count
    always_comb
    begin
        pkt.op    = op_t'(cmd.req_type);
        pkt.data  = cmd.data_byte;
        pkt.count = (cmd.bit_count > MAX_FIXED_BITS) ? MAX_FIXED_BITS : cmd.bit_count;
    end

    assign cmd.ready = (fill_reg != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign pop       = q_pop && q_valid;
    assign q_valid   = (fill_reg != 2'd0);
    assign q_head    = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= pkt;
        end
    end

endmodule

[sv/bitrd_back.sv]
`timescale 1ns / 1ps

module bitrd_back #(
    parameter int  BUFFER_BYTES = bitrd_pkg::BUFFER_BYTES_DEF,
    localparam int AW           = $clog2(BUFFER_BYTES),
    localparam int CW           = $clog2(BUFFER_BYTES + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bitrd_pkg::pkt_t   q_head,
    input  logic              q_valid,
    output logic              q_pop,
    output logic              ram_we,
    output logic [AW-1:0]     ram_waddr,
    output logic [7:0]        ram_wdata,
    output logic              ram_re,
    output logic [AW-1:0]     ram_raddr,
    input  logic [7:0]        ram_rdata,
    bitrd_res_if.source       result
);

    import bitrd_pkg::*;

    localparam logic [CW-1:0] FULL = CW'(BUFFER_BYTES);

    state_t         state_reg, state_next;
    mode_t          mode_reg, mode_next;
    logic [CW-1:0]  read_index_reg, read_index_next;
    logic [CW-1:0]  bytes_held_reg, bytes_held_next;
    logic [2:0]     bit_offset_reg, bit_offset_next;
    logic           error_reg, error_next;
    logic           err_start_reg, err_start_next;
    logic [6:0]     rem_reg, rem_next;
    logic [5:0]     zeros_reg, zeros_next;
    logic [63:0]    acc_reg, acc_next;
    logic           out_valid_reg, out_valid_next;
    logic [63:0]    out_value_reg, out_value_next;
    logic           out_error_reg, out_error_next;
    logic           out_ovf_reg, out_ovf_next;

    logic           slot_free;
    logic           avail;
    logic           starts_read;
    logic [7:0]     aligned;
    logic [3:0]     room;
    logic [3:0]     take;
    logic [7:0]     chunk;
    logic [3:0]     lz;
    logic [6:0]     zero_total;
    logic [3:0]     limit_gap;
    logic [63:0]    acc_shift;
    logic [63:0]    seed_value;
    logic [3:0]     consume;
    logic [3:0]     off_sum;
    logic           wrap;
    logic           work_finish;
    logic           work_err;
    logic           to_suffix;
    logic [63:0]    work_value;

    function automatic logic [3:0] lead_zeros(input logic [7:0] w);
        logic [3:0] n;
        logic       found;
        n     = 4'd8;
        found = 1'b0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!found && w[i])
            begin
                n     = 4'(7 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    assign slot_free  = !out_valid_reg || result.ready;
    assign q_pop      = (state_reg == ST_IDLE) && q_valid && slot_free;
    assign avail      = (read_index_reg < bytes_held_reg);
    assign starts_read = (q_head.op == OP_GOLOMB) ||
                         ((q_head.op == OP_FIXED) && (q_head.count != 7'd0));

    // current byte left-aligned at the bit offset
    assign aligned    = ram_rdata << bit_offset_reg;
    assign room       = 4'd8 - {1'b0, bit_offset_reg};
    assign take       = (rem_reg < {3'b000, room}) ? rem_reg[3:0] : room;
    assign chunk      = aligned >> (4'd8 - take);
    assign lz         = lead_zeros(aligned);
    assign zero_total = {1'b0, zeros_reg} +
                        ((aligned != 8'd0) ? {3'b000, lz} : {3'b000, room});
    // zeros still allowed before the run limit; at most eight when the limit is reached
    assign limit_gap  = 4'(GOLOMB_LIMIT - {1'b0, zeros_reg});
    assign acc_shift  = (acc_reg << take) | {56'd0, chunk};
    assign seed_value = (64'd1 << zeros_reg) - 64'd1;

    // what one byte step does in each mode
    always_comb
    begin
        consume     = take;
        work_finish = 1'b0;
        work_err    = 1'b0;
        to_suffix   = 1'b0;
        work_value  = 64'd0;
        unique case (mode_reg)
            MD_FIXED:
            begin
                work_finish = (rem_reg == {3'b000, take});
                work_value  = acc_shift;
            end
            MD_SUFFIX:
            begin
                work_finish = (rem_reg == {3'b000, take});
                // acc was seeded with a one, so it already holds 2^n + bits
                work_value  = acc_shift - 64'd1;
            end
            MD_ZERO:
            begin
                if (err_start_reg)
                begin
                    // error already set: one bit, then the code gives 0
                    consume     = 4'd1;
                    work_finish = 1'b1;
                end
                else if (zero_total >= GOLOMB_LIMIT)
                begin
                    consume     = limit_gap;
                    work_finish = 1'b1;
                    work_err    = 1'b1;
                end
                else if (aligned != 8'd0)
                begin
                    consume = lz + 4'd1;
                    if (zero_total == 7'd0)
                    begin
                        work_finish = 1'b1;
                    end
                    else
                    begin
                        to_suffix = 1'b1;
                    end
                end
                else
                begin
                    consume = room;
                end
            end
            default:
            begin
                work_finish = 1'b1;
            end
        endcase
    end

    assign off_sum = {1'b0, bit_offset_reg} + consume;
    assign wrap    = off_sum[3];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop && starts_read)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = avail ? ST_WORK : ST_IDLE;
            end
            ST_WORK:
            begin
                if (work_finish)
                begin
                    state_next = ST_IDLE;
                end
                else if (wrap)
                begin
                    state_next = ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mode_next       = mode_reg;
        read_index_next = read_index_reg;
        bytes_held_next = bytes_held_reg;
        bit_offset_next = bit_offset_reg;
        error_next      = error_reg;
        err_start_next  = err_start_reg;
        rem_next        = rem_reg;
        zeros_next      = zeros_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_value_next  = out_value_reg;
        out_error_next  = out_error_reg;
        out_ovf_next    = out_ovf_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    unique case (q_head.op)
                        OP_START:
                        begin
                            read_index_next = '0;
                            bytes_held_next = '0;
                            bit_offset_next = 3'd0;
                            error_next      = 1'b0;
                            out_valid_next  = 1'b1;
                            out_value_next  = 64'd0;
                            out_error_next  = 1'b0;
                            out_ovf_next    = 1'b0;
                        end
                        OP_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            out_value_next = 64'd0;
                            out_error_next = error_reg;
                            if (bytes_held_reg < FULL)
                            begin
                                ram_we          = 1'b1;
                                bytes_held_next = bytes_held_reg + CW'(1);
                                out_ovf_next    = 1'b0;
                            end
                            else
                            begin
                                out_ovf_next = 1'b1;
                            end
                        end
                        OP_FIXED:
                        begin
                            mode_next = MD_FIXED;
                            rem_next  = q_head.count;
                            acc_next  = 64'd0;
                            if (q_head.count == 7'd0)
                            begin
                                out_valid_next = 1'b1;
                                out_value_next = 64'd0;
                                out_error_next = error_reg;
                                out_ovf_next   = 1'b0;
                            end
                        end
                        OP_GOLOMB:
                        begin
                            mode_next      = MD_ZERO;
                            zeros_next     = 6'd0;
                            rem_next       = 7'd0;
                            err_start_next = error_reg;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                if (avail)
                begin
                    ram_re = 1'b1;
                end
                else
                begin
                    // data ran out: fixed gives 0, a code gives 2^n - 1
                    error_next     = 1'b1;
                    out_valid_next = 1'b1;
                    out_value_next = (mode_reg == MD_FIXED) ? 64'd0 : seed_value;
                    out_error_next = 1'b1;
                    out_ovf_next   = 1'b0;
                end
            end
            ST_WORK:
            begin
                if (wrap)
                begin
                    read_index_next = read_index_reg + CW'(1);
                    bit_offset_next = 3'd0;
                end
                else
                begin
                    bit_offset_next = off_sum[2:0];
                end
                if (mode_reg == MD_ZERO)
                begin
                    zeros_next = zero_total[5:0];
                    if (to_suffix)
                    begin
                        mode_next = MD_SUFFIX;
                        rem_next  = zero_total;
                        acc_next  = 64'd1;
                    end
                end
                else
                begin
                    rem_next = rem_reg - {3'b000, take};
                    acc_next = acc_shift;
                end
                if (work_err)
                begin
                    error_next = 1'b1;
                end
                if (work_finish)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = work_value;
                    out_error_next = error_reg || work_err;
                    out_ovf_next   = 1'b0;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    assign ram_waddr = bytes_held_reg[AW-1:0];
    assign ram_wdata = q_head.data;
    assign ram_raddr = read_index_reg[AW-1:0];

    assign result.valid    = out_valid_reg;
    assign result.value    = out_value_reg;
    assign result.error    = out_error_reg;
    assign result.overflow = out_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MD_FIXED;
            read_index_reg <= '0;
            bytes_held_reg <= '0;
            bit_offset_reg <= 3'd0;
            error_reg      <= 1'b0;
            err_start_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            read_index_reg <= read_index_next;
            bytes_held_reg <= bytes_held_next;
            bit_offset_reg <= bit_offset_next;
            error_reg      <= error_next;
            err_start_reg  <= err_start_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        zeros_reg     <= zeros_next;
        acc_reg       <= acc_next;
        out_value_reg <= out_value_next;
        out_error_reg <= out_error_next;
        out_ovf_reg   <= out_ovf_next;
    end

endmodule

[sv/msb_bit_reader_exp_golomb.sv]
`timescale 1ns / 1ps

// channel   direction  payload                                  request meaning
// cmd       in         req_type[1:0] data_byte[7:0] bit_count   start, push, fixed read, code read
// result    out        value[63:0] error overflow               one per request, in order
//
// start, push and zero-length reads: the queue entry, then the back end's result register
// reads: each byte touched takes a ram fetch, then bit extraction, before the result register;
//   an extra extraction step where a code's suffix starts in the byte that ends its zero
//   run, and an empty fetch when the data runs out
// reset: asynchronous, clears offsets, counts, sticky error and the request queue
// a two-entry queue lets new requests in while the back end reads or a result waits

module msb_bit_reader_exp_golomb #(
    parameter int BUFFER_BYTES = bitrd_pkg::BUFFER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bitrd_cmd_if.sink   cmd,
    bitrd_res_if.source result
);

    import bitrd_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    // queue head handed from the front end to the back end
    pkt_t          q_head;
    logic          q_valid;
    logic          q_pop;

    // byte buffer port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // front end: takes requests, decodes and clamps them, queues them
    bitrd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_head  (q_head),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    // byte buffer, written on push, read a byte at a time by the back end
    bitrd_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // back end: owns the read position and sticky error, walks the bits
    bitrd_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .result    (result)
    );

endmodule

[test/tb_msb_bit_reader_exp_golomb.sv]
`timescale 1ns / 1ps

// the directed table comes first, then random work: well-formed buffers of
// exp-golomb codes and fixed fields, read back in order, mixed with noise
module tb_msb_bit_reader_exp_golomb;
    import bitrd_pkg::*;

    localparam int DEPTH      = BUFFER_BYTES_DEF;
    localparam int ITEM_GOAL  = 1850;
    localparam int CYCLE_CAP  = 500000;
    localparam int HOLD_LEN   = 400;
    localparam int TAIL_WAIT  = 60;
    localparam int PRINT_CAP  = 100;

    // one result as the block should return it
    typedef struct packed {
        logic [63:0] value;
        logic        error;
        logic        overflow;
    } res_word_t;

    // one row of the directed table; typed rows carry their result as written
    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic [6:0]  count;
        logic        typed;
        logic [63:0] value;
        logic        error;
        logic        overflow;
    } plan_row_t;

    localparam int PLAN_LEN = 25;
    localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
        // zero-length read straight after reset leaves everything clear
        '{OP_FIXED,  8'h00, 7'd0,   1'b1, 64'd0, 1'b0, 1'b0},
        // reads on an empty buffer run out and raise the sticky error
        '{OP_FIXED,  8'h00, 7'd8,   1'b1, 64'd0, 1'b1, 1'b0},
        '{OP_GOLOMB, 8'h00, 7'd0,   1'b1, 64'd0, 1'b1, 1'b0},
        // start clears the error
        '{OP_START,  8'h00, 7'd0,   1'b1, 64'd0, 1'b0, 1'b0},
        // fill the whole buffer: eight mixed bytes, then eight zero bytes
        '{OP_PUSH,   8'hFF, 7'd0,   1'b0, 64'd0, 1'b0, 1'b0},
        '{OP_PUSH,   8'h80, 7'd127, 1'b0, 64'd0, 1'b0, 1'b0},
        '{OP_PUSH,   8'h5A, 7'd0,   1'b0, 64'd0, 1'b0, 1'b0},
        '{OP_PUSH,   8'hC3, 7'd0,   1'b0, 64'd0, 1'b0, 1'b0},
        '{OP_PUSH,   8'h01, 7'd0,   1'b0, 64'd0, 1'b0, 1'b0},
        '{OP_PUSH,   8'h7E, 7'd0,   1'b0, 64'd0, 1'b0, 1'b0},
        '{OP_PUSH,   8'h00, 7'd0,   1'b0, 64'd0, 1'b0, 1'b0},
        '{OP_PUSH,   8'h3C, 7'd0,   1'b0, 64'd0, 1'b0, 1'b0},
        '{OP_PUSH,   8'h00, 7'd0,   1'b0, 64'd0, 1'b0, 1'b0},
        '{OP_PUSH,   8'h00, 7'd0,   1'b0, 64'd0, 1'b0, 1'b0},
        '{OP_PUSH,   8'h00, 7'd0,   1'b0, 64'd0, 1'b0, 1'b0},
        '{OP_PUSH,   8'h00, 7'd0,   1'b0, 64'd0, 1'b0, 1'b0},
        '{OP_PUSH,   8'h00, 7'd0,   1'b0, 64'd0, 1'b0, 1'b0},
        '{OP_PUSH,   8'h00, 7'd0,   1'b0, 64'd0, 1'b0, 1'b0},
        '{OP_PUSH,   8'h00, 7'd0,   1'b0, 64'd0, 1'b0, 1'b0},
        '{OP_PUSH,   8'h00, 7'd0,   1'b0, 64'd0, 1'b0, 1'b0},
        // buffer full: the byte is dropped and flagged
        '{OP_PUSH,   8'hFF, 7'd0,   1'b1, 64'd0, 1'b0, 1'b1},
        // count above the maximum reads 64 bits, the first eight bytes
        '{OP_FIXED,  8'h00, 7'd127, 1'b1, 64'hFF80_5AC3_017E_003C, 1'b0, 1'b0},
        // sixty-four zeros in a row abort the code
        '{OP_GOLOMB, 8'hFF, 7'd0,   1'b1, 64'd0, 1'b1, 1'b0},
        // error already set and nothing left
        '{OP_GOLOMB, 8'h00, 7'd0,   1'b1, 64'd0, 1'b1, 1'b0},
        '{OP_START,  8'h00, 7'd0,   1'b1, 64'd0, 1'b0, 1'b0}
    };

    logic clk;
    logic rst_n;

    bitrd_cmd_if req_ch ();
    bitrd_res_if res_ch ();

    msb_bit_reader_exp_golomb #(
        .BUFFER_BYTES (DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (req_ch),
        .result (res_ch)
    );

    // shadow copy of the reader state
    logic [7:0]  buf_mem [DEPTH];
    int          rd_byte;
    int          held;
    int          bit_pos;
    logic        sticky_err;

    res_word_t   awaited_results [$];
    int          mismatch_count;
    int          checked;
    int          sent;
    int          cycles;
    bit          quiet;
    bit          hold_rx_req;

    // take n bits msb first; running out sets the error and yields zero
    function automatic logic [63:0] fetch_bits(input int n);
        logic [63:0] acc;
        logic [7:0]  cur;
        logic [7:0]  mask;
        int          left;
        int          d;
        acc  = '0;
        left = n;
        while (left != 0)
        begin
            if (rd_byte >= held || rd_byte >= DEPTH)
            begin
                sticky_err = 1'b1;
                return '0;
            end
            d    = (bit_pos + left > 8) ? 8 - bit_pos : left;
            cur  = buf_mem[rd_byte] >> (8 - bit_pos - d);
            mask = 8'hFF >> (8 - d);
            acc  = (acc << d) | {56'd0, cur & mask};
            bit_pos += d;
            left    -= d;
            if (bit_pos == 8)
            begin
                rd_byte++;
                bit_pos = 0;
            end
        end
        return acc;
    endfunction

    // unsigned exp-golomb: count zeros to a one, then read that many bits
    function automatic logic [63:0] decode_ue();
        int          zeros;
        bit          done;
        logic [63:0] suffix;
        zeros = 0;
        done  = 1'b0;
        while (!done)
        begin
            if (fetch_bits(1) != 0 || sticky_err)
                done = 1'b1;
            else
            begin
                zeros++;
                if (zeros >= GOLOMB_LIMIT)
                begin
                    sticky_err = 1'b1;
                    return '0;
                end
            end
        end
        suffix = fetch_bits(zeros);
        return (64'd1 << zeros) + suffix - 64'd1;
    endfunction

    function automatic res_word_t decode_request(input op_t op, input logic [7:0] data,
                                                 input logic [6:0] count);
        res_word_t r;
        r = '0;
        unique case (op)
            OP_START:
            begin
                rd_byte    = 0;
                held       = 0;
                bit_pos    = 0;
                sticky_err = 1'b0;
            end
            OP_PUSH:
            begin
                if (held < DEPTH)
                begin
                    buf_mem[held] = data;
                    held++;
                end
                else
                    r.overflow = 1'b1;
            end
            OP_FIXED:
                r.value = fetch_bits((count > MAX_FIXED_BITS) ? int'(MAX_FIXED_BITS)
                                                              : int'(count));
            default:
                r.value = decode_ue();
        endcase
        r.error = sticky_err;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch on %s at result %0d: got %h, want %h",
                     field, checked, got, want);
    endtask

    task automatic check_result();
        res_word_t want;
        if (awaited_results.size() == 0)
        begin
            report_mismatch("unexpected result", res_ch.value, 64'd0);
            return;
        end
        want = awaited_results.pop_front();
        if (res_ch.value !== want.value)
            report_mismatch("value", res_ch.value, want.value);
        if (res_ch.error !== want.error)
            report_mismatch("error", {63'd0, res_ch.error}, {63'd0, want.error});
        if (res_ch.overflow !== want.overflow)
            report_mismatch("overflow", {63'd0, res_ch.overflow}, {63'd0, want.overflow});
        checked++;
    endtask

    // offer one request, idling at random first; the prediction is taken at acceptance
    task automatic send_request(input op_t op, input logic [7:0] data, input logic [6:0] count,
                                input bit typed, input res_word_t typed_res);
        res_word_t predicted;
        while (!quiet && $urandom_range(99) < 13)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= op;
        req_ch.data_byte <= data;
        req_ch.bit_count <= count;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = decode_request(op, data, count);
        awaited_results.push_back(typed ? typed_res : predicted);
        sent++;
        // long receiver hold-off so the request queue fills and stalls the input
        if (sent == 500)
            hold_rx_req = 1'b1;
        quiet = (sent >= 1200 && sent < 1500);
    endtask

    task automatic pause_until_drained();
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // noise: any request, zero bytes common so long zero runs turn up
    task automatic send_noise();
        logic [7:0] data;
        logic [6:0] count;
        op_t        op;
        repeat ($urandom_range(10, 1))
        begin
            op    = op_t'($urandom_range(3));
            data  = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255));
            count = 7'($urandom_range(127));
            send_request(op, data, count, 1'b0, '0);
        end
    endtask

    // well-formed buffer: codes and fixed fields packed msb first, pushed, read back
    task automatic run_sequence();
        bit         bits_q [$];
        op_t        rd_ops [$];
        logic [6:0] rd_counts [$];
        logic [6:0] count;
        logic [7:0] data;
        bit         room;
        int         n;
        int         w;
        int         nbytes;
        int         idx;
        room = 1'b1;
        while (room)
        begin
            if ($urandom_range(9) < 6)
            begin
                n = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(5);
                if (bits_q.size() + 2 * n + 1 > 8 * DEPTH)
                    room = 1'b0;
                else
                begin
                    repeat (n) bits_q.push_back(1'b0);
                    bits_q.push_back(1'b1);
                    repeat (n) bits_q.push_back(1'($urandom_range(1)));
                    count = 7'($urandom_range(127));
                    rd_ops.push_back(OP_GOLOMB);
                    rd_counts.push_back(count);
                end
            end
            else
            begin
                w = ($urandom_range(3) == 0) ? $urandom_range(64) : $urandom_range(12);
                if (bits_q.size() + w > 8 * DEPTH)
                    room = 1'b0;
                else
                begin
                    repeat (w) bits_q.push_back(1'($urandom_range(1)));
                    count = 7'(w);
                    if (w == 64 && $urandom_range(1))
                        count = 7'($urandom_range(127, 64));
                    rd_ops.push_back(OP_FIXED);
                    rd_counts.push_back(count);
                end
            end
            if ($urandom_range(7) == 0)
                room = 1'b0;
        end

        nbytes = (bits_q.size() + 7) / 8;
        // sometimes cut the data short so the reads run out
        if (nbytes > 0 && $urandom_range(5) == 0)
            nbytes = $urandom_range(nbytes - 1);

        if ($urandom_range(9) != 0)
            send_request(OP_START, 8'($urandom_range(255)), 7'($urandom_range(127)), 1'b0, '0);
        for (int i = 0; i < nbytes; i++)
        begin
            for (int j = 0; j < 8; j++)
            begin
                idx = 8 * i + j;
                data[7 - j] = (idx < bits_q.size()) ? bits_q[idx] : 1'($urandom_range(1));
            end
            send_request(OP_PUSH, data, 7'($urandom_range(127)), 1'b0, '0);
        end
        // extra pushes land after the packed data or overflow a full buffer
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(4, 1))
                send_request(OP_PUSH, 8'($urandom_range(255)), 7'd0, 1'b0, '0);

        for (int i = 0; i < rd_ops.size(); i++)
            send_request(rd_ops[i], 8'($urandom_range(255)), rd_counts[i], 1'b0, '0);

        // reads past the end of the packed data, which may run out and set the error
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(3, 1))
                send_request($urandom_range(1) ? OP_FIXED : OP_GOLOMB, 8'd0,
                             7'($urandom_range(127)), 1'b0, '0);
    endtask

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: check at each handshake, then choose ready for the next cycle
    initial
    begin : rx_side
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                check_result();
            if (hold_rx_req)
            begin
                stall_left  = HOLD_LEN;
                hold_rx_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (!rst_n)
                res_ch.ready <= 1'b0;
            else
                res_ch.ready <= quiet || ($urandom_range(99) >= 13);
        end
    end

    initial
    begin : tx_side
        res_word_t typed_res;
        bit        paused;
        paused           = 1'b0;
        mismatch_count   = 0;
        checked          = 0;
        sent             = 0;
        cycles           = 0;
        quiet            = 1'b0;
        hold_rx_req      = 1'b0;
        rd_byte          = 0;
        held             = 0;
        bit_pos          = 0;
        sticky_err       = 1'b0;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= OP_START;
        req_ch.data_byte <= 8'd0;
        req_ch.bit_count <= 7'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            typed_res = '{PLAN[i].value, PLAN[i].error, PLAN[i].overflow};
            send_request(PLAN[i].op, PLAN[i].data, PLAN[i].count, PLAN[i].typed, typed_res);
        end

        // random part
        while (sent < ITEM_GOAL)
        begin
            if ($urandom_range(7) == 0)
                send_noise();
            else
                run_sequence();
            // sender pause until every pending result is back
            if (!paused && sent >= 900)
            begin
                pause_until_drained();
                paused = 1'b1;
            end
        end

        pause_until_drained();
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
